@@ rtl/sads_pkg.sv @@
// Package for the shared-array double stack.
// Holds operation and status codes and the memory control struct.
// No dependencies.
package sads_pkg;

  typedef enum logic [1:0] {
    FUNC_PUSH  = 2'd0,
    FUNC_POP   = 2'd1,
    FUNC_CLEAR = 2'd2,
    FUNC_NOP   = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  localparam int unsigned WORD_W  = 32;
  localparam int unsigned COUNT_W = 6;

  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } mem_ctl_t;

endpackage

@@ rtl/sads_mem.sv @@
// Shared word store for both stacks: one port, write or registered read.
// Depends on sads_pkg for the control struct and word width.
module sads_mem import sads_pkg::*; #(
  parameter int unsigned DEPTH = 32,
  parameter int unsigned AW    = 5
) (
  input  logic              clk,
  input  mem_ctl_t          ctl,
  input  logic [AW-1:0]     addr,
  input  logic [WORD_W-1:0] wdata,
  output logic [WORD_W-1:0] rdata
);

  logic [WORD_W-1:0] store [DEPTH];

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      store[addr] <= wdata;
    end
    if (ctl.rd_en) begin
      rdata <= store[addr];
    end
  end

endmodule

@@ rtl/sads_ctrl.sv @@
// Pointer control for the double stack: counts, address generation, status.
// Depends on sads_pkg for codes and the memory control struct.
module sads_ctrl import sads_pkg::*; #(
  parameter int unsigned DEPTH = 32,
  parameter int unsigned AW    = 5,
  parameter int unsigned CW    = 6
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  logic [1:0]        func,
  input  logic              which_stack,
  output mem_ctl_t          ctl,
  output logic [AW-1:0]     addr,
  output logic              done,
  output status_t           status,
  output logic              pop_ok,
  output logic [CW-1:0]     total
);

  localparam logic [CW:0]   DEPTH_S = (CW+1)'(DEPTH);
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
  localparam logic [CW-1:0] ONE_C   = CW'(1);

  logic [CW-1:0] low_count, low_count_next;
  logic [CW-1:0] high_count, high_count_next;
  logic [CW:0]   sum;
  logic [CW-1:0] addr_wide;
  status_t       status_next;
  logic          pop_hit;
  mem_ctl_t      ctl_raw;

  assign sum   = {1'b0, low_count} + {1'b0, high_count};
  assign total = sum[CW-1:0];

  always_comb begin
    low_count_next  = low_count;
    high_count_next = high_count;
    status_next     = ST_OK;
    pop_hit         = 1'b0;
    ctl_raw         = '0;
    addr_wide       = '0;
    unique case (func_t'(func))
      FUNC_PUSH: begin
        if (sum >= DEPTH_S) begin
          status_next = ST_FULL;
        end else if (!which_stack) begin
          addr_wide      = low_count;
          low_count_next = low_count + ONE_C;
          ctl_raw.wr_en  = 1'b1;
        end else begin
          addr_wide       = DEPTH_C - ONE_C - high_count;
          high_count_next = high_count + ONE_C;
          ctl_raw.wr_en   = 1'b1;
        end
      end
      FUNC_POP: begin
        if (!which_stack) begin
          if (low_count == '0) begin
            status_next = ST_EMPTY;
          end else begin
            addr_wide      = low_count - ONE_C;
            low_count_next = low_count - ONE_C;
            ctl_raw.rd_en  = 1'b1;
            pop_hit        = 1'b1;
          end
        end else begin
          if (high_count == '0) begin
            status_next = ST_EMPTY;
          end else begin
            addr_wide       = DEPTH_C - high_count;
            high_count_next = high_count - ONE_C;
            ctl_raw.rd_en   = 1'b1;
            pop_hit         = 1'b1;
          end
        end
      end
      FUNC_CLEAR: begin
        low_count_next  = '0;
        high_count_next = '0;
      end
      FUNC_NOP: begin
      end
      default: begin
      end
    endcase
  end

  // Touch memory only for an accepted request.
  assign ctl  = mem_ctl_t'{wr_en: ctl_raw.wr_en & accept, rd_en: ctl_raw.rd_en & accept};
  assign addr = addr_wide[AW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      low_count  <= '0;
      high_count <= '0;
      done       <= 1'b0;
      pop_ok     <= 1'b0;
    end else begin
      done <= accept;
      if (accept) begin
        low_count  <= low_count_next;
        high_count <= high_count_next;
        pop_ok     <= pop_hit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status <= status_next;
    end
  end

endmodule

@@ rtl/shared_array_double_stack.sv @@
// Shared-array double stack: bottom stack grows up, top stack grows down.
// Usage:
//   Raise start with func, which_stack and push_value; the request is taken
//   at a clock edge where start is high and busy is low. busy stays low, so
//   a new request may be issued every cycle.
//   Each request gives one result in the next cycle: done is high for exactly
//   that cycle, with status, pop_value, total_count and all_empty valid.
//   Throughput is one request per cycle. A pop reads the single-port store at
//   the accepting edge and its word appears from the store's read register in
//   the done cycle; a push writes the store at the accepting edge, so a pop
//   right behind it sees the new word.
//   The receiver cannot stall: results must be taken in their done cycle.
//   Reset (rst, synchronous) empties both stacks and drops done; store
//   contents are not cleared and are never read before being written.
//   total_count carries the low six bits of the occupancy.
// Depends on sads_pkg, sads_ctrl and sads_mem.
module shared_array_double_stack import sads_pkg::*; #(
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  input  logic [1:0]               func,
  input  logic                     which_stack,
  input  logic signed [WORD_W-1:0] push_value,
  output logic                     done,
  output logic [1:0]               status,
  output logic signed [WORD_W-1:0] pop_value,
  output logic [COUNT_W-1:0]       total_count,
  output logic                     all_empty
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic                accept;
  mem_ctl_t            ctl;
  logic [AW-1:0]       addr;
  logic [WORD_W-1:0]   rdata;
  status_t             status_q;
  logic                pop_ok;
  logic [CW-1:0]       total;
  logic [CW+COUNT_W-1:0] total_ext;

  assign busy   = 1'b0;
  assign accept = start & ~busy;

  sads_ctrl #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .CW    (CW)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .func        (func),
    .which_stack (which_stack),
    .ctl         (ctl),
    .addr        (addr),
    .done        (done),
    .status      (status_q),
    .pop_ok      (pop_ok),
    .total       (total)
  );

  sads_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .ctl   (ctl),
    .addr  (addr),
    .wdata (push_value),
    .rdata (rdata)
  );

  assign total_ext   = {{COUNT_W{1'b0}}, total};
  assign status      = status_q;
  assign pop_value   = pop_ok ? $signed(rdata) : '0;
  assign total_count = total_ext[COUNT_W-1:0];
  assign all_empty   = (total == '0);

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 100ps
// Testbench for shared_array_double_stack: directed, fill-to-full and random traffic.
// Predicts every request against its own copy of both stacks and checks each result.
// Depends on sads_pkg and the shared_array_double_stack RTL.
module tb;
  import sads_pkg::*;

  localparam int unsigned DEPTH = 32;
  localparam int unsigned STALL_LIMIT = 200;
  localparam int unsigned FLUSH_CYCLES = 4;

  typedef struct {
    status_t                  status;
    logic signed [WORD_W-1:0] pop_value;
    logic [COUNT_W-1:0]       total_count;
    logic                     all_empty;
  } stack_result_t;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     start = 1'b0;
  logic [1:0]               func = FUNC_NOP;
  logic                     which_stack = 1'b0;
  logic signed [WORD_W-1:0] push_value = '0;
  logic                     busy;
  logic                     done;
  logic [1:0]               status;
  logic signed [WORD_W-1:0] pop_value;
  logic [COUNT_W-1:0]       total_count;
  logic                     all_empty;

  stack_result_t            pending_results[$];
  logic signed [WORD_W-1:0] model_store [DEPTH];
  int unsigned              bottom_depth = 0;
  int unsigned              top_depth = 0;
  int unsigned              error_count = 0;
  int unsigned              stall_cycles = 0;
  bit                       no_gaps = 1'b0;

  shared_array_double_stack #(.DEPTH(DEPTH)) dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .func(func),
    .which_stack(which_stack),
    .push_value(push_value),
    .done(done),
    .status(status),
    .pop_value(pop_value),
    .total_count(total_count),
    .all_empty(all_empty)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Apply one request to the local stacks and return the result it must give.
  function automatic stack_result_t predict_stack_op(input func_t op, input logic sel,
                                                     input logic signed [WORD_W-1:0] word);
    stack_result_t r;
    r.status = ST_OK;
    r.pop_value = '0;
    case (op)
      FUNC_PUSH: begin
        if (bottom_depth + top_depth >= DEPTH) begin
          r.status = ST_FULL;
        end else if (!sel) begin
          model_store[bottom_depth] = word;
          bottom_depth++;
        end else begin
          model_store[DEPTH - 1 - top_depth] = word;
          top_depth++;
        end
      end
      FUNC_POP: begin
        if (!sel) begin
          if (bottom_depth == 0) begin
            r.status = ST_EMPTY;
          end else begin
            bottom_depth--;
            r.pop_value = model_store[bottom_depth];
          end
        end else begin
          if (top_depth == 0) begin
            r.status = ST_EMPTY;
          end else begin
            r.pop_value = model_store[DEPTH - top_depth];
            top_depth--;
          end
        end
      end
      FUNC_CLEAR: begin
        bottom_depth = 0;
        top_depth = 0;
      end
      default: ;
    endcase
    r.total_count = COUNT_W'(bottom_depth + top_depth);
    r.all_empty = (bottom_depth + top_depth == 0);
    return r;
  endfunction

  task automatic send_request(input func_t op, input logic sel,
                              input logic signed [WORD_W-1:0] word);
    int unsigned gap;
    gap = no_gaps ? 0 : $urandom_range(0, 8);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    func <= op;
    which_stack <= sel;
    push_value <= word;
    do @(posedge clk); while (busy !== 1'b0);
    pending_results.push_back(predict_stack_op(op, sel, word));
  endtask

  // Hold off new requests until every outstanding result has come back.
  task automatic wait_results_drained();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic check_field(input string name, input logic signed [WORD_W-1:0] want,
                             input logic signed [WORD_W-1:0] got);
    if (got !== want) begin
      error_count++;
      $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin : result_check
    stack_result_t want;
    if (!rst && done === 1'b1) begin
      if (pending_results.size() == 0) begin
        error_count++;
        $display("%0t: unexpected result: expected none, got status %0d pop %0d count %0d",
                 $time, status, pop_value, total_count);
      end else begin
        want = pending_results.pop_front();
        check_field("status", WORD_W'(want.status), WORD_W'(status));
        check_field("pop_value", want.pop_value, pop_value);
        check_field("total_count", WORD_W'(want.total_count), WORD_W'(total_count));
        check_field("all_empty", WORD_W'(want.all_empty), WORD_W'(all_empty));
      end
    end
  end

  // Count cycles with no request taken and no result; a stuck block ends the run.
  always @(posedge clk) begin
    if (rst || (start && busy === 1'b0) || done === 1'b1) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic test_directed_ops();
    no_gaps = 1'b0;
    send_request(FUNC_POP, 1'b0, '0);
    send_request(FUNC_POP, 1'b1, 32'sh7fffffff);
    send_request(FUNC_PUSH, 1'b0, 32'sh7fffffff);
    send_request(FUNC_PUSH, 1'b1, 32'sh80000000);
    send_request(FUNC_PUSH, 1'b0, -32'sd1);
    send_request(FUNC_PUSH, 1'b1, '0);
    send_request(FUNC_NOP, 1'b0, 32'sh55555555);
    send_request(FUNC_NOP, 1'b1, 32'shaaaaaaaa);
    send_request(FUNC_POP, 1'b0, '1);
    send_request(FUNC_POP, 1'b1, '0);
    send_request(FUNC_POP, 1'b0, '0);
    // bottom is empty while top still holds a word: must report empty
    send_request(FUNC_POP, 1'b0, '0);
    send_request(FUNC_PUSH, 1'b0, 32'sh12345678);
    send_request(FUNC_CLEAR, 1'b1, 32'sh0f0f0f0f);
    send_request(FUNC_POP, 1'b1, '0);
    send_request(FUNC_POP, 1'b0, '0);
    send_request(FUNC_CLEAR, 1'b0, '0);
    // back-to-back push then pop: the pop must see the fresh word
    no_gaps = 1'b1;
    send_request(FUNC_PUSH, 1'b1, 32'shdeadbeef);
    send_request(FUNC_POP, 1'b1, '0);
    send_request(FUNC_PUSH, 1'b0, 32'sh00000001);
    send_request(FUNC_POP, 1'b0, '0);
    no_gaps = 1'b0;
    wait_results_drained();
  endtask

  task automatic test_fill_and_overflow(input int unsigned rounds);
    int unsigned split;
    logic        sel;
    repeat (rounds) begin
      no_gaps = ($urandom_range(0, 1) == 0);
      split = $urandom_range(0, 2);
      send_request(FUNC_CLEAR, 1'($urandom_range(0, 1)), $urandom);
      while (bottom_depth + top_depth < DEPTH) begin
        sel = (split == 2) ? logic'($urandom_range(0, 1)) : logic'(split);
        send_request(FUNC_PUSH, sel, $urandom);
      end
      repeat ($urandom_range(2, 4))
        send_request(FUNC_PUSH, 1'($urandom_range(0, 1)), $urandom);
      repeat ($urandom_range(DEPTH / 2, DEPTH + 4))
        send_request(FUNC_POP, 1'($urandom_range(0, 1)), $urandom);
    end
    no_gaps = 1'b0;
    wait_results_drained();
  endtask

  task automatic test_random_traffic(input int unsigned count);
    int unsigned pick;
    func_t       op;
    for (int unsigned n = 0; n < count; n++) begin
      if (n % 50 == 0) no_gaps = ($urandom_range(0, 3) == 0);
      if (n % 150 == 149) wait_results_drained();
      pick = $urandom_range(0, 99);
      if (pick < 50) op = FUNC_PUSH;
      else if (pick < 88) op = FUNC_POP;
      else if (pick < 94) op = FUNC_NOP;
      else op = FUNC_CLEAR;
      send_request(op, 1'($urandom_range(0, 1)), $urandom);
    end
    no_gaps = 1'b0;
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    test_directed_ops();
    test_fill_and_overflow(8);
    test_random_traffic(840);
    wait_results_drained();
    repeat (FLUSH_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
